// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the voxel line traversal checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold at the same edge as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Assertion failed: same-cycle implication.");

// The consequent must hold at the edge after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Assertion failed: next-cycle implication.");

`endif

// ===== hw/rtl/vlt3_pkg.sv =====
// ----------------------------------------------------------------------------
// vlt3_pkg
// Types, constants and helpers shared by the voxel line traversal block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vlt3_pkg;

    localparam int COORD_W      = 16;
    localparam int AXES         = 3;
    localparam int MAX_SPAN_DEF = 63;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [1:0]                axis_t;

    localparam axis_t AXIS_X = 2'd0;
    localparam axis_t AXIS_Y = 2'd1;
    localparam axis_t AXIS_Z = 2'd2;

    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t start_z;
        coord_t end_x;
        coord_t end_y;
        coord_t end_z;
    } ray_t;

    typedef struct packed {
        coord_t voxel_x;
        coord_t voxel_y;
        coord_t voxel_z;
        logic   last;
        logic   too_long;
    } voxel_t;

    typedef struct packed {
        logic load;
        logic setup;
        logic advance;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
    } dp_stat_t;

    function automatic axis_t next_axis(input axis_t a);
        axis_t r;
        case (a)
            AXIS_X:  r = AXIS_Y;
            AXIS_Y:  r = AXIS_Z;
            default: r = AXIS_X;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/vlt3_stream_if.sv =====
// ----------------------------------------------------------------------------
// vlt3_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface vlt3_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/voxel_line_traversal_3d.sv =====
// ----------------------------------------------------------------------------
// voxel_line_traversal_3d
// 3D Bresenham voxel traversal from a start voxel to an end voxel.
// ----------------------------------------------------------------------------
// The ray channel takes one item holding start and end grid indices. The
// voxel channel returns every voxel of the line, start first, one item per
// voxel, with last set on the final one. A ray whose dominant span exceeds
// MAX_SPAN returns a single item at the start voxel with too_long and last.
// After the ray is accepted, the load step registers the axis deltas and the
// setup step picks the dominant axis and the error terms; the first voxel is
// offered after setup. After that one voxel leaves per cycle from the step
// unit while the receiver takes them. One ray is handled at a time; ray
// ready rises in the cycle after the last voxel is taken. When the receiver
// stalls, the current voxel is held and traversal waits. Reset returns the
// block to idle; ray ready rises in the cycle after reset is released.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module voxel_line_traversal_3d #(
    parameter int MAX_SPAN = vlt3_pkg::MAX_SPAN_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    vlt3_stream_if.sink   ray,
    vlt3_stream_if.source voxel
);
    import vlt3_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    voxel_t   voxel_data;

    vlt3_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .ray_valid   (ray.valid),
        .ray_ready   (ray.ready),
        .voxel_valid (voxel.valid),
        .voxel_ready (voxel.ready),
        .cmd         (cmd),
        .stat        (stat)
    );

    vlt3_dp #(
        .MAX_SPAN (MAX_SPAN)
    ) u_dp (
        .clk   (clk),
        .ray   (ray.data),
        .cmd   (cmd),
        .stat  (stat),
        .voxel (voxel_data)
    );

    assign voxel.data = voxel_data;

endmodule

`default_nettype wire

// ===== hw/rtl/vlt3_ctrl.sv =====
// ----------------------------------------------------------------------------
// vlt3_ctrl
// Controller: sequences ray load, setup and voxel emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vlt3_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               ray_valid,
    output logic               ray_ready,
    output logic               voxel_valid,
    input  logic               voxel_ready,
    output vlt3_pkg::dp_cmd_t  cmd,
    input  vlt3_pkg::dp_stat_t stat
);
    import vlt3_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_EMIT
    } state_t;

    state_t state_reg;
    logic   ray_ready_reg;
    logic   voxel_valid_reg;

    assign ray_ready   = ray_ready_reg;
    assign voxel_valid = voxel_valid_reg;

    always_comb
    begin
        cmd.load    = ray_valid && ray_ready_reg;
        cmd.setup   = (state_reg == ST_SETUP);
        cmd.advance = (state_reg == ST_EMIT) && voxel_ready && !stat.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            ray_ready_reg   <= 1'b0;
            voxel_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (ray_valid && ray_ready_reg)
                    begin
                        state_reg     <= ST_SETUP;
                        ray_ready_reg <= 1'b0;
                    end
                    else
                    begin
                        ray_ready_reg <= 1'b1;
                    end
                end
                ST_SETUP:
                begin
                    state_reg       <= ST_EMIT;
                    voxel_valid_reg <= 1'b1;
                end
                ST_EMIT:
                begin
                    if (voxel_ready && stat.last)
                    begin
                        state_reg       <= ST_IDLE;
                        voxel_valid_reg <= 1'b0;
                        ray_ready_reg   <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg       <= ST_IDLE;
                    ray_ready_reg   <= 1'b0;
                    voxel_valid_reg <= 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/vlt3_dp.sv =====
// ----------------------------------------------------------------------------
// vlt3_dp
// Datapath: deltas, dominant axis, error terms and the current voxel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vlt3_dp #(
    parameter int MAX_SPAN = vlt3_pkg::MAX_SPAN_DEF
) (
    input  logic               clk,
    input  vlt3_pkg::ray_t     ray,
    input  vlt3_pkg::dp_cmd_t  cmd,
    output vlt3_pkg::dp_stat_t stat,
    output vlt3_pkg::voxel_t   voxel
);
    import vlt3_pkg::*;

    localparam int SPAN_W = $clog2(MAX_SPAN + 1);
    localparam int ERR_W  = SPAN_W + 3;

    typedef logic [SPAN_W-1:0]       span_t;
    typedef logic signed [ERR_W-1:0] err_t;

    coord_t              start_c [AXES];
    coord_t              end_c   [AXES];
    logic [COORD_W-1:0]  mag_c   [AXES];
    logic                neg_c   [AXES];
    logic                nz_c    [AXES];

    coord_t              pos_reg [AXES];
    coord_t              pos_next[AXES];
    logic [COORD_W-1:0]  dlt_reg [AXES];
    logic                neg_reg [AXES];
    logic                nz_reg  [AXES];

    axis_t dom_reg, s1_reg, s2_reg;
    span_t span_reg, cnt_reg, d1_reg, d2_reg;
    err_t  e1_reg, e2_reg;
    logic  too_long_reg;

    axis_t              dom_c, s1_c, s2_c;
    logic [COORD_W-1:0] span_full;
    span_t              span_c, d1_c, d2_c;
    err_t               e1_next, e2_next;
    logic               step1, step2;

    assign start_c[0] = ray.start_x;
    assign start_c[1] = ray.start_y;
    assign start_c[2] = ray.start_z;
    assign end_c[0]   = ray.end_x;
    assign end_c[1]   = ray.end_y;
    assign end_c[2]   = ray.end_z;

    always_comb
    begin
        logic signed [COORD_W:0] d;
        for (int a = 0; a < AXES; a++)
        begin
            d = {end_c[a][COORD_W-1], end_c[a]} - {start_c[a][COORD_W-1], start_c[a]};
            neg_c[a] = d[COORD_W];
            nz_c[a]  = |d;
            mag_c[a] = d[COORD_W] ? COORD_W'(-d) : d[COORD_W-1:0];
        end
    end

    always_comb
    begin
        if (dlt_reg[0] >= dlt_reg[1] && dlt_reg[0] >= dlt_reg[2])
        begin
            dom_c = AXIS_X;
        end
        else if (dlt_reg[1] >= dlt_reg[2])
        begin
            dom_c = AXIS_Y;
        end
        else
        begin
            dom_c = AXIS_Z;
        end
        s1_c      = next_axis(dom_c);
        s2_c      = next_axis(s1_c);
        span_full = dlt_reg[dom_c];
        span_c    = span_full[SPAN_W-1:0];
        d1_c      = dlt_reg[s1_c][SPAN_W-1:0];
        d2_c      = dlt_reg[s2_c][SPAN_W-1:0];
    end

    assign step1 = (e1_reg > 0);
    assign step2 = (e2_reg > 0);

    always_comb
    begin
        e1_next = e1_reg + $signed({2'b00, d1_reg, 1'b0});
        e2_next = e2_reg + $signed({2'b00, d2_reg, 1'b0});
        if (step1)
        begin
            e1_next = e1_next - $signed({2'b00, span_reg, 1'b0});
        end
        if (step2)
        begin
            e2_next = e2_next - $signed({2'b00, span_reg, 1'b0});
        end
    end

    always_comb
    begin
        logic mv;
        for (int a = 0; a < AXES; a++)
        begin
            mv = (axis_t'(a) == dom_reg) || (axis_t'(a) == s1_reg && step1)
                 || (axis_t'(a) == s2_reg && step2);
            if (mv && nz_reg[a])
            begin
                pos_next[a] = neg_reg[a] ? pos_reg[a] - 1'b1 : pos_reg[a] + 1'b1;
            end
            else
            begin
                pos_next[a] = pos_reg[a];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                pos_reg[a] <= start_c[a];
                dlt_reg[a] <= mag_c[a];
                neg_reg[a] <= neg_c[a];
                nz_reg[a]  <= nz_c[a];
            end
        end
        else if (cmd.advance)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                pos_reg[a] <= pos_next[a];
            end
        end

        if (cmd.setup)
        begin
            dom_reg      <= dom_c;
            s1_reg       <= s1_c;
            s2_reg       <= s2_c;
            span_reg     <= span_c;
            cnt_reg      <= span_c;
            d1_reg       <= d1_c;
            d2_reg       <= d2_c;
            too_long_reg <= (span_full > COORD_W'(MAX_SPAN));
            e1_reg       <= $signed({2'b00, d1_c, 1'b0}) - $signed({3'b000, span_c});
            e2_reg       <= $signed({2'b00, d2_c, 1'b0}) - $signed({3'b000, span_c});
        end
        else if (cmd.advance)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            e1_reg  <= e1_next;
            e2_reg  <= e2_next;
        end
    end

    assign stat.last      = too_long_reg || (cnt_reg == '0);
    assign voxel.voxel_x  = pos_reg[0];
    assign voxel.voxel_y  = pos_reg[1];
    assign voxel.voxel_z  = pos_reg[2];
    assign voxel.last     = stat.last;
    assign voxel.too_long = too_long_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/vlt3_checker.sv =====
// ----------------------------------------------------------------------------
// vlt3_checker
// Port-level checks on the voxel line traversal block, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module vlt3_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             ray_valid,
    input logic             ray_ready,
    input logic             voxel_valid,
    input logic             voxel_ready,
    input vlt3_pkg::voxel_t voxel_data
);
    import vlt3_pkg::*;

    `ASSERT_IMPL(a_too_long_is_last, clk, rst_n, voxel_valid && voxel_data.too_long, voxel_data.last)
    `ASSERT_IMPL(a_one_ray_at_a_time, clk, rst_n, ray_ready, !voxel_valid)
    `ASSERT_IMPL(a_first_voxel_latency, clk, rst_n, $past(ray_valid && ray_ready, 2), voxel_valid)
    `ASSERT_NEXT(a_ready_after_last, clk, rst_n, voxel_valid && voxel_ready && voxel_data.last, ray_ready)
    `ASSERT_NEXT(a_stall_holds, clk, rst_n, voxel_valid && !voxel_ready, voxel_valid && $stable(voxel_data))

endmodule

bind voxel_line_traversal_3d vlt3_checker u_vlt3_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .ray_valid   (ray.valid),
    .ray_ready   (ray.ready),
    .voxel_valid (voxel.valid),
    .voxel_ready (voxel.ready),
    .voxel_data  (voxel.data)
);

`default_nettype wire
